// ===== sv/ebq_pkg.sv =====
// ----------------------------------------------------------------------------
// ebq_pkg
// Shared types and constants for the encoder and button qualifier.
// ----------------------------------------------------------------------------
`default_nettype none

package ebq_pkg;

   localparam int unsigned TIME_W  = 32;
   localparam int unsigned POS_W   = 32;
   localparam int unsigned CFG_W   = 16;
   localparam int unsigned CSR_A_W = 1;

   localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd30;
   localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd1500;

   typedef enum logic [CSR_A_W-1:0] {
      CSR_DEBOUNCE   = 1'b0,
      CSR_LONG_PRESS = 1'b1
   } csr_addr_type;

   // settings handed from the register block to the button logic
   typedef struct packed {
      logic [CFG_W-1:0] debounce_ms;
      logic [CFG_W-1:0] long_hold_ms;
   } cfg_type;

   // one accepted sample
   typedef struct packed {
      logic              chan_a;
      logic              chan_b;
      logic              button_level;
      logic [TIME_W-1:0] now_ms;
   } sample_type;

   // button events for one sample
   typedef struct packed {
      logic click;
      logic long_press;
      logic pressed;
   } btn_evt_type;

endpackage

`default_nettype wire

// ===== sv/ebq_if.sv =====
// ----------------------------------------------------------------------------
// ebq channel interfaces
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface ebq_req_if import ebq_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              chan_a;
   logic              chan_b;
   logic              button_level;
   logic [TIME_W-1:0] now_ms;

   modport source (output valid, chan_a, chan_b, button_level, now_ms, input ready);
   modport sink   (input valid, chan_a, chan_b, button_level, now_ms, output ready);
endinterface

interface ebq_rsp_if import ebq_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] position;
   logic                    click;
   logic                    long_press;
   logic                    pressed;

   modport source (output valid, position, click, long_press, pressed, input ready);
   modport sink   (input valid, position, click, long_press, pressed, output ready);
endinterface

interface ebq_csr_if import ebq_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CSR_A_W-1:0] addr;
   logic [CFG_W-1:0]   data;

   modport source (output valid, addr, data, input ready);
   modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

// ===== sv/encoder_button_qualifier.sv =====
// ----------------------------------------------------------------------------
// encoder_button_qualifier
// Rotary encoder position counter with debounced push button, click and
// long-press events, one result per sample.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake      payload
//   req_ch    in    valid/ready    chan_a, chan_b, button_level, now_ms
//   rsp_ch    out   valid/ready    position, click, long_press, pressed
//   csr_ch    in    valid/ready    addr (0 debounce_ms, 1 long_hold_ms), data
//
// one sample per cycle while rsp_ch is not stalled; each sample passes the
// sample register, then the result register around one pass of compare and
// add logic, before its result is offered on rsp_ch.
// reset is synchronous and restores the default times.
// a stall on rsp_ch holds the result register, then the sample register,
// and then drops req_ch.ready. register writes are taken in every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_button_qualifier import ebq_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   ebq_req_if.sink   req_ch,
   ebq_rsp_if.source rsp_ch,
   ebq_csr_if.sink   csr_ch
);

   cfg_type     cfg;
   sample_type  sample_ff;
   logic        sample_valid_ff;
   logic        rsp_valid_ff;
   logic        advance;
   logic        step_en;

   logic signed [POS_W-1:0] position_in;
   logic signed [POS_W-1:0] position_ff;
   btn_evt_type             evt_in;
   btn_evt_type             evt_ff;

   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign step_en      = sample_valid_ff && advance;
   assign req_ch.ready = !sample_valid_ff || advance;
   assign csr_ch.ready = 1'b1;

   ebq_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (csr_ch.valid),
      .wr_addr (csr_ch.addr),
      .wr_data (csr_ch.data),
      .cfg     (cfg)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         sample_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         sample_ff.chan_a       <= req_ch.chan_a;
         sample_ff.chan_b       <= req_ch.chan_b;
         sample_ff.button_level <= req_ch.button_level;
         sample_ff.now_ms       <= req_ch.now_ms;
      end
   end

   ebq_encoder u_encoder (
      .clock       (clock),
      .reset       (reset),
      .step_en     (step_en),
      .chan_a      (sample_ff.chan_a),
      .chan_b      (sample_ff.chan_b),
      .position_in (position_in)
   );

   ebq_button u_button (
      .clock        (clock),
      .reset        (reset),
      .step_en      (step_en),
      .button_level (sample_ff.button_level),
      .now_ms       (sample_ff.now_ms),
      .cfg          (cfg),
      .evt          (evt_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= sample_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         position_ff <= position_in;
         evt_ff      <= evt_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.position   = position_ff;
   assign rsp_ch.click      = evt_ff.click;
   assign rsp_ch.long_press = evt_ff.long_press;
   assign rsp_ch.pressed    = evt_ff.pressed;

   // a click ends a press, so it can never come with a long press
   a_click_excl_long: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(evt_ff.click && evt_ff.long_press))
      else $error("click and long press on one result");

   a_click_released: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && evt_ff.click) |-> !evt_ff.pressed)
      else $error("click while button still held");

   a_long_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && evt_ff.long_press) |-> evt_ff.pressed)
      else $error("long press while button released");

   // a sample at work and a waiting result both move once the output frees up
   a_pipe_moves: assert property (@(posedge clock) disable iff (reset)
      (sample_valid_ff && rsp_valid_ff && rsp_ch.ready) |=> rsp_valid_ff)
      else $error("result lost behind a drained output");

endmodule

`default_nettype wire

// ===== sv/ebq_csr.sv =====
// ----------------------------------------------------------------------------
// ebq_csr
// Debounce and long-press time registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ebq_csr import ebq_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire logic [CSR_A_W-1:0] wr_addr,
   input  wire logic [CFG_W-1:0] wr_data,
   output cfg_type               cfg
);

   logic [CFG_W-1:0] debounce_ff, debounce_in;
   logic [CFG_W-1:0] long_press_ff, long_press_in;

   always_comb begin
      debounce_in   = debounce_ff;
      long_press_in = long_press_ff;
      if (wr_en) begin
         unique case (csr_addr_type'(wr_addr))
            CSR_DEBOUNCE:   debounce_in   = wr_data;
            CSR_LONG_PRESS: long_press_in = wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= DEBOUNCE_RESET;
         long_press_ff <= LONG_PRESS_RESET;
      end else begin
         debounce_ff   <= debounce_in;
         long_press_ff <= long_press_in;
      end
   end

   assign cfg.debounce_ms  = debounce_ff;
   assign cfg.long_hold_ms = long_press_ff;

endmodule

`default_nettype wire

// ===== sv/ebq_encoder.sv =====
// ----------------------------------------------------------------------------
// ebq_encoder
// Quadrature position counter, counting on rising edges of channel A.
// ----------------------------------------------------------------------------
`default_nettype none

module ebq_encoder import ebq_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step_en,
   input  wire logic             chan_a,
   input  wire logic             chan_b,
   output logic signed [POS_W-1:0] position_in
);

   logic                    prev_a_ff, prev_a_in;
   logic signed [POS_W-1:0] count_ff;

   always_comb begin
      position_in = count_ff;
      if (chan_a && !prev_a_ff) begin
         // b low counts up, b high counts down
         if (chan_b) begin
            position_in = count_ff - POS_W'(1);
         end else begin
            position_in = count_ff + POS_W'(1);
         end
      end
      prev_a_in = chan_a;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_a_ff <= 1'b1;
         count_ff  <= '0;
      end else if (step_en) begin
         prev_a_ff <= prev_a_in;
         count_ff  <= position_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/ebq_button.sv =====
// ----------------------------------------------------------------------------
// ebq_button
// Time-based button debounce with click and long-press detection.
// ----------------------------------------------------------------------------
`default_nettype none

module ebq_button import ebq_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step_en,
   input  wire logic              button_level,
   input  wire logic [TIME_W-1:0] now_ms,
   input  wire cfg_type           cfg,
   output btn_evt_type            evt
);

   logic              stable_ff, stable_in;
   logic [TIME_W-1:0] last_change_ff, last_change_in;
   logic [TIME_W-1:0] press_start_ff, press_start_in;
   logic              long_fired_ff, long_fired_in;

   logic [TIME_W-1:0] since_change;
   logic [TIME_W-1:0] held_old;
   logic [TIME_W-1:0] held_new;
   logic              change;
   logic              press_edge;
   logic              release_edge;
   logic              fired_mid;
   logic              click;
   logic              long_press;

   always_comb begin
      since_change = now_ms - last_change_ff;
      held_old     = now_ms - press_start_ff;
      change       = (button_level != stable_ff) &&
                     (since_change > TIME_W'(cfg.debounce_ms));
      press_edge   = change && stable_ff;
      release_edge = change && !stable_ff;

      click = release_edge && !long_fired_ff && (held_old < TIME_W'(cfg.long_hold_ms));

      stable_in      = change ? button_level : stable_ff;
      last_change_in = change ? now_ms : last_change_ff;
      press_start_in = press_edge ? now_ms : press_start_ff;
      fired_mid      = press_edge ? 1'b0 : long_fired_ff;

      // a fresh press restarts the hold time at zero
      held_new   = press_edge ? '0 : held_old;
      long_press = !stable_in && !fired_mid && (held_new >= TIME_W'(cfg.long_hold_ms));
      long_fired_in = fired_mid || long_press;

      evt.click      = click;
      evt.long_press = long_press;
      evt.pressed    = !stable_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff      <= 1'b1;
         last_change_ff <= '0;
         press_start_ff <= '0;
         long_fired_ff  <= 1'b0;
      end else if (step_en) begin
         stable_ff      <= stable_in;
         last_change_ff <= last_change_in;
         press_start_ff <= press_start_in;
         long_fired_ff  <= long_fired_in;
      end
   end

endmodule

`default_nettype wire
